// File: sv/text_console_cursor_engine_core_defines.svh
// Assertion macros shared by the console engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH

// Same-cycle check, sampled on aclk, off while reset is asserted.
`define TCCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that holds in the cycle after the condition.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tcce_pkg.sv
// Shared constants and types for the text console cursor engine.
package tcce_pkg;

    localparam int MAX_COLS_DEF = 80;
    localparam int MAX_ROWS_DEF = 25;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int IDX_W      = 11;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_READ_CELL = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 8'd0,
        CFG_FIRST_ROW = 8'd1,
        CFG_LAST_ROW = 8'd2,
        CFG_COLOUR_ATTR = 8'd3
    } cfg_idx_t;

    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

    localparam int TAB_STEP = 4;

    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0720;

    localparam logic [COL_W-1:0]  LINE_WIDTH_RST  = 7'd80;
    localparam logic [ROW_W-1:0]  FIRST_ROW_RST   = 5'd0;
    localparam logic [ROW_W-1:0]  LAST_ROW_RST    = 5'd24;
    localparam logic [ATTR_W-1:0] COLOUR_ATTR_RST = 8'h07;

endpackage

// File: sv/text_console_cursor_engine_core.sv
// Flow: an item is captured in the idle state; its result word is registered in the execute state
// once the output register is free. A new item is taken only in the idle state, after the last
// one has been executed and any scroll it started is done; a put that scrolls walks the viewport
// one cell per cycle through the cell memory's single write port.
// Reset: synchronous, active low; then a clear pass writes blank cells to all MAX_COLS*MAX_ROWS
// cells (2000 by default) while s_ready stays low.
`include "text_console_cursor_engine_core_defines.svh"

module text_console_cursor_engine_core #(
    parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcce_pkg::MAX_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcce_pkg::OP_W-1:0]       s_operation,
    input  logic [tcce_pkg::CHAR_W-1:0]     s_char_code,
    input  logic [tcce_pkg::ROW_W-1:0]      s_row_number,
    input  logic [tcce_pkg::COL_W-1:0]      s_col_number,
    input  logic [tcce_pkg::IDX_W-1:0]      s_cell_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tcce_pkg::CELL_W-1:0]     m_cell_data,
    output logic [tcce_pkg::ROW_W-1:0]      m_cursor_row,
    output logic [tcce_pkg::COL_W-1:0]      m_cursor_col,
    output logic                            m_scrolled,
    output logic                            m_accepted,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W      = tcce_pkg::ROW_W;
    localparam int COL_W      = tcce_pkg::COL_W;
    localparam int CHAR_W     = tcce_pkg::CHAR_W;
    localparam int CELL_W     = tcce_pkg::CELL_W;
    localparam int ATTR_W     = tcce_pkg::ATTR_W;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int W_W        = COL_W + 1;
    localparam int PROD_W     = ROW_W + W_W + 1;
    localparam int RI_W       = (ADDR_W > tcce_pkg::IDX_W) ? ADDR_W : tcce_pkg::IDX_W;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_EXEC   = 4'b0100,
        ST_SCROLL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [COL_W-1:0]  line_width_reg;
    logic [ROW_W-1:0]  first_row_reg, last_row_reg;
    logic [ATTR_W-1:0] colour_attr_reg;

    // cursor
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;

    // captured item
    tcce_pkg::op_t     op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [ROW_W-1:0]  row_in_reg;
    logic [COL_W-1:0]  col_in_reg;
    logic              oor_reg;

    // clear pass and scroll walk
    logic [CNT_W-1:0] clr_reg;
    logic [CNT_W-1:0] scr_addr_reg, scr_addr_next;
    logic [CNT_W-1:0] copy_end_reg, blank_end_reg;
    logic             cp_valid_reg, cp_valid_next;
    logic [CNT_W-1:0] cp_addr_reg;

    // result word
    logic              m_valid_reg;
    logic [CELL_W-1:0] m_cell_data_reg;
    logic [ROW_W-1:0]  m_cursor_row_reg;
    logic [COL_W-1:0]  m_cursor_col_reg;
    logic              m_scrolled_reg, m_accepted_reg;

    // memory port
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    // effective geometry
    logic [W_W-1:0]   eff_w;
    logic [COL_W-1:0] endc;
    logic [ROW_W-1:0] eff_f, last_sat, eff_l;
    logic [ROW_W-1:0] row0;
    logic [COL_W-1:0] col0;
    logic [CELL_W-1:0] blank;

    // put-char evaluation
    logic [ROW_W:0]    pc_row;
    logic [COL_W-1:0]  pc_col;
    logic [COL_W:0]    col_sum;
    logic              pc_we;
    logic [ROW_W-1:0]  pc_wrow;
    logic [COL_W-1:0]  pc_wcol;
    logic [CELL_W-1:0] pc_wdata;
    logic              need_scroll;
    logic [ROW_W-1:0]  final_row;
    logic [PROD_W-1:0] put_addr_w;
    logic [PROD_W-1:0] first_prod, last_prod;

    logic              s_acc, out_free, exec_go, set_ok;
    logic [RI_W-1:0]   rd_idx;
    logic [CNT_W-1:0]  scr_src;
    logic              copy_phase, scroll_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_go   = (state_reg == ST_EXEC) && out_free;
    assign rd_idx    = RI_W'(s_cell_index);

    always_comb begin
        if (line_width_reg == '0) begin
            eff_w = W_W'(1);
        end else if (int'(line_width_reg) > MAX_COLS) begin
            eff_w = W_W'(MAX_COLS);
        end else begin
            eff_w = W_W'(line_width_reg);
        end
        endc = COL_W'(eff_w - W_W'(1));
        eff_f = (int'(first_row_reg) > MAX_ROWS - 1) ? ROW_W'(MAX_ROWS - 1) : first_row_reg;
        last_sat = (int'(last_row_reg) > MAX_ROWS - 1) ? ROW_W'(MAX_ROWS - 1) : last_row_reg;
        eff_l = (last_sat < eff_f) ? eff_f : last_sat;
        col0  = (cur_col_reg > endc) ? endc : cur_col_reg;
        row0  = (cur_row_reg > eff_l) ? eff_l : cur_row_reg;
        blank = {colour_attr_reg, tcce_pkg::CH_SPACE};
    end

    always_comb begin
        pc_row   = {1'b0, row0};
        pc_col   = col0;
        pc_we    = 1'b0;
        pc_wrow  = row0;
        pc_wcol  = col0;
        pc_wdata = blank;
        col_sum  = '0;
        case (ch_reg)
            tcce_pkg::CH_CR: begin
                pc_col = '0;
            end
            tcce_pkg::CH_LF: begin
                pc_col = '0;
                pc_row = {1'b0, row0} + (ROW_W+1)'(1);
            end
            tcce_pkg::CH_TAB: begin
                col_sum = {1'b0, col0} + (COL_W+1)'(tcce_pkg::TAB_STEP);
                if (col_sum > {1'b0, endc}) begin
                    pc_col = '0;
                    pc_row = {1'b0, row0} + (ROW_W+1)'(1);
                end else begin
                    pc_col = col_sum[COL_W-1:0];
                end
            end
            tcce_pkg::CH_BS: begin
                if (col0 == '0) begin
                    if (row0 > eff_f) begin
                        pc_row  = {1'b0, row0} - (ROW_W+1)'(1);
                        pc_col  = endc;
                        pc_we   = 1'b1;
                        pc_wrow = row0 - ROW_W'(1);
                        pc_wcol = endc;
                    end
                end else begin
                    pc_col  = col0 - COL_W'(1);
                    pc_we   = 1'b1;
                    pc_wcol = col0 - COL_W'(1);
                end
            end
            default: begin
                if (ch_reg inside {[tcce_pkg::CH_SPACE:tcce_pkg::CH_PRINT_LAST]}) begin
                    pc_we    = 1'b1;
                    pc_wdata = {colour_attr_reg, ch_reg};
                    col_sum  = {1'b0, col0} + (COL_W+1)'(1);
                    if (col_sum > {1'b0, endc}) begin
                        pc_col = '0;
                        pc_row = {1'b0, row0} + (ROW_W+1)'(1);
                    end else begin
                        pc_col = col_sum[COL_W-1:0];
                    end
                end
            end
        endcase
        need_scroll = pc_row > {1'b0, eff_l};
        final_row   = need_scroll ? eff_l : pc_row[ROW_W-1:0];
        put_addr_w  = PROD_W'(pc_wrow) * PROD_W'(eff_w) + PROD_W'(pc_wcol);
        first_prod  = PROD_W'(eff_f) * PROD_W'(eff_w);
        last_prod   = PROD_W'(eff_l) * PROD_W'(eff_w);
        set_ok      = !((row_in_reg > eff_l) || (col_in_reg > endc));
    end

    // scroll walk: copy rows up one cell a cycle, each write in the cycle after its read
    assign scr_src     = scr_addr_reg + CNT_W'(eff_w);
    assign copy_phase  = scr_addr_reg < copy_end_reg;
    assign scroll_done = !copy_phase && !cp_valid_reg && (scr_addr_reg >= blank_end_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = blank;
        ram_re    = 1'b0;
        ram_raddr = '0;
        scr_addr_next = scr_addr_reg;
        cp_valid_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[ADDR_W-1:0];
                ram_wdata = tcce_pkg::CLEAR_CELL;
            end
            ST_IDLE: begin
                ram_re    = s_acc;
                ram_raddr = rd_idx[ADDR_W-1:0];
            end
            ST_EXEC: begin
                if (exec_go) begin
                    scr_addr_next = CNT_W'(first_prod);
                end
                if (exec_go && (op_reg == tcce_pkg::OP_PUT_CHAR) && pc_we) begin
                    ram_we    = 1'b1;
                    ram_waddr = put_addr_w[ADDR_W-1:0];
                    ram_wdata = pc_wdata;
                end
            end
            ST_SCROLL: begin
                if (cp_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_addr_reg[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (copy_phase) begin
                    ram_re        = 1'b1;
                    ram_raddr     = scr_src[ADDR_W-1:0];
                    cp_valid_next = 1'b1;
                    scr_addr_next = scr_addr_reg + CNT_W'(1);
                end else if (!cp_valid_reg && (scr_addr_reg < blank_end_reg)) begin
                    ram_we        = 1'b1;
                    ram_waddr     = scr_addr_reg[ADDR_W-1:0];
                    ram_wdata     = blank;
                    scr_addr_next = scr_addr_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CNT_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                    case (op_reg)
                        tcce_pkg::OP_PUT_CHAR: begin
                            cur_row_next = final_row;
                            cur_col_next = pc_col;
                            if (need_scroll) begin
                                state_next = ST_SCROLL;
                            end
                        end
                        tcce_pkg::OP_SET_CURSOR: begin
                            if (set_ok) begin
                                cur_row_next = row_in_reg;
                                cur_col_next = col_in_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                if (scroll_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            cp_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            line_width_reg  <= tcce_pkg::LINE_WIDTH_RST;
            first_row_reg   <= tcce_pkg::FIRST_ROW_RST;
            last_row_reg    <= tcce_pkg::LAST_ROW_RST;
            colour_attr_reg <= tcce_pkg::COLOUR_ATTR_RST;
        end else begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            cp_valid_reg <= cp_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + CNT_W'(1);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tcce_pkg::CFG_LINE_WIDTH:  line_width_reg  <= cfg_data[COL_W-1:0];
                    tcce_pkg::CFG_FIRST_ROW:   first_row_reg   <= cfg_data[ROW_W-1:0];
                    tcce_pkg::CFG_LAST_ROW:    last_row_reg    <= cfg_data[ROW_W-1:0];
                    tcce_pkg::CFG_COLOUR_ATTR: colour_attr_reg <= cfg_data[ATTR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (exec_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg     <= tcce_pkg::op_t'(s_operation);
            ch_reg     <= s_char_code;
            row_in_reg <= s_row_number;
            col_in_reg <= s_col_number;
            oor_reg    <= int'(s_cell_index) >= CELL_COUNT;
        end
        scr_addr_reg <= scr_addr_next;
        cp_addr_reg  <= scr_addr_reg;
        if (exec_go) begin
            m_cursor_row_reg <= cur_row_next;
            m_cursor_col_reg <= cur_col_next;
            case (op_reg)
                tcce_pkg::OP_PUT_CHAR: begin
                    m_cell_data_reg <= '0;
                    m_scrolled_reg  <= need_scroll;
                    m_accepted_reg  <= 1'b1;
                    copy_end_reg    <= CNT_W'(last_prod);
                    blank_end_reg   <= CNT_W'(last_prod + PROD_W'(eff_w));
                end
                tcce_pkg::OP_SET_CURSOR: begin
                    m_cell_data_reg <= '0;
                    m_scrolled_reg  <= 1'b0;
                    m_accepted_reg  <= set_ok;
                end
                tcce_pkg::OP_READ_CELL: begin
                    m_cell_data_reg <= oor_reg ? '0 : ram_rdata;
                    m_scrolled_reg  <= 1'b0;
                    m_accepted_reg  <= 1'b1;
                end
                default: begin
                    m_cell_data_reg <= '0;
                    m_scrolled_reg  <= 1'b0;
                    m_accepted_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_data  = m_cell_data_reg;
    assign m_cursor_row = m_cursor_row_reg;
    assign m_cursor_col = m_cursor_col_reg;
    assign m_scrolled   = m_scrolled_reg;
    assign m_accepted   = m_accepted_reg;

    tcce_ram #(
        .DATA_W(CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    `TCCE_ASSERT(a_put_addr_range, (exec_go && (op_reg == tcce_pkg::OP_PUT_CHAR) && pc_we) |-> (int'(put_addr_w) < CELL_COUNT), "cell write beyond store")
    `TCCE_ASSERT(a_copy_in_scroll, cp_valid_reg |-> (state_reg == ST_SCROLL), "copy write outside scroll")
    `TCCE_ASSERT(a_scroll_row, (m_valid_reg && m_scrolled_reg) |-> (m_cursor_row_reg == eff_l), "scrolled word not on last row")
    `TCCE_ASSERT(a_result_src, $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC), "result word not from execute")
    `TCCE_ASSERT_NEXT(a_scroll_end, (state_reg == ST_SCROLL) && scroll_done, state_reg == ST_IDLE, "scroll did not finish")

endmodule

// File: sv/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
